### hw/rtl/eisu_pkg.sv
// package: shared types and constants for the external interrupt sense unit
`timescale 1ns / 1ps

package eisu_pkg;

   // fixed field widths
   localparam int MAX_LINES    = 8;
   localparam int LINE_W       = 3;
   localparam int LINE_CNT_W   = 4;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 8;

   // command codes of a request beat
   typedef enum logic [1:0] {
      CMD_PIN    = 2'd0,
      CMD_ENABLE = 2'd1,
      CMD_SENSE  = 2'd2
   } cmd_type;

   // sense modes of one line
   typedef enum logic [1:0] {
      MODE_LOW    = 2'd0,
      MODE_TOGGLE = 2'd1,
      MODE_FALL   = 2'd2,
      MODE_RISE   = 2'd3
   } mode_type;

   // register indexes of the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_ASYNC_LINES = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_COUNT  = 2'd1;

   // reset values
   localparam logic [MAX_LINES-1:0]  ASYNC_RESET      = 8'h00;
   localparam logic [LINE_CNT_W-1:0] LINE_COUNT_RESET = 4'd8;

endpackage

### hw/rtl/eisu_if.sv
// interfaces: request, response and csr channels of the sense unit
`timescale 1ns / 1ps

interface eisu_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      cmd;
   logic [eisu_pkg::LINE_W-1:0]     line;
   logic                            pin_level;
   logic [eisu_pkg::MAX_LINES-1:0]  enable_mask;
   logic [2*eisu_pkg::MAX_LINES-1:0] sense_bits;

   modport source (output valid, cmd, line, pin_level, enable_mask, sense_bits,
                   input ready);
   modport sink   (input valid, cmd, line, pin_level, enable_mask, sense_bits,
                   output ready);
endinterface

interface eisu_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [eisu_pkg::MAX_LINES-1:0] raise_edge;
   logic [eisu_pkg::MAX_LINES-1:0] raise_level;
   logic [eisu_pkg::MAX_LINES-1:0] clear_edge;
   logic [eisu_pkg::MAX_LINES-1:0] clear_level;

   modport source (output valid, raise_edge, raise_level, clear_edge, clear_level,
                   input ready);
   modport sink   (input valid, raise_edge, raise_level, clear_edge, clear_level,
                   output ready);
endinterface

interface eisu_csr_if;
   logic                             valid;
   logic                             ready;
   logic [eisu_pkg::CSR_INDEX_W-1:0] index;
   logic [eisu_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/external_interrupt_sense_unit.sv
// top level: external interrupt edge/level sense unit
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    cmd, line, pin_level, enable_mask, sense_bits
//   rsp_chan  out  valid/ready    raise_edge, raise_level, clear_edge, clear_level
//   csr_chan  in   valid/ready    index, data (0 async_lines, 1 line_count)
//
// one beat per cycle in and out while the response is not stalled; a request beat is
// taken into the input register, then loaded into the output register, and leaves from there.
// the line state is updated as the beat moves from the input register to the
// output register, so back-to-back beats see each other's effects in order.
// reset is synchronous and returns the valid flags, configuration and line state to
// their reset values (pins idle high); csr writes are always accepted. a stalled response
// holds the output register; req ready drops while the input register is full and cannot advance.
`timescale 1ns / 1ps

module external_interrupt_sense_unit #(
   parameter int LINES = 8
) (
   input  logic        clock,
   input  logic        reset,
   eisu_req_if.sink    req_chan,
   eisu_rsp_if.source  rsp_chan,
   eisu_csr_if.sink    csr_chan
);

   localparam int ML  = eisu_pkg::MAX_LINES;
   localparam int LCW = eisu_pkg::LINE_CNT_W;
   localparam int LW  = eisu_pkg::LINE_W;

   // configuration registers
   logic [ML-1:0]  async_ff;
   logic [LCW-1:0] line_count_ff;

   // line state
   logic [LINES-1:0]    pin_ff,     pin_in;
   logic [LINES-1:0]    enabled_ff, enabled_in;
   eisu_pkg::mode_type  mode_ff [LINES];
   eisu_pkg::mode_type  mode_in [LINES];

   // input register
   logic                 s1_valid_ff;
   logic [1:0]           s1_cmd_ff;
   logic [LW-1:0]        s1_line_ff;
   logic                 s1_level_ff;
   logic [ML-1:0]        s1_enable_ff;
   logic [2*ML-1:0]      s1_sense_ff;

   // output register
   logic          out_valid_ff;
   logic [ML-1:0] re_ff, rl_ff, ce_ff, cl_ff;
   logic [ML-1:0] re_in, rl_in, ce_in, cl_in;

   logic           advance;
   logic           req_take;
   logic [LCW-1:0] active_n;

   // pipeline flow
   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // number of lines in use, saturated to the built line count
   assign active_n = (line_count_ff > LCW'(LINES)) ? LCW'(LINES) : line_count_ff;

   // per-line sense logic
   always_comb begin
      eisu_pkg::mode_type new_mode;
      logic               old_pin;
      logic               up;
      logic               down;
      logic               en;
      re_in = '0;
      rl_in = '0;
      ce_in = '0;
      cl_in = '0;
      pin_in     = pin_ff;
      enabled_in = enabled_ff;
      for (int i = 0; i < LINES; i++) begin
         mode_in[i] = mode_ff[i];
      end
      for (int i = 0; i < LINES; i++) begin
         old_pin = pin_ff[i];
         up      = !old_pin && s1_level_ff;
         down    = old_pin && !s1_level_ff;
         en      = s1_enable_ff[i];
         if (async_ff[i]) begin
            new_mode = eisu_pkg::mode_type'({1'b1, s1_sense_ff[2*i]});
         end else begin
            new_mode = eisu_pkg::mode_type'(s1_sense_ff[2*i +: 2]);
         end
         if (LCW'(i) < active_n) begin
            case (s1_cmd_ff)
               eisu_pkg::CMD_PIN: begin
                  if (s1_line_ff == LW'(i)) begin
                     if (enabled_ff[i]) begin
                        case (mode_ff[i])
                           eisu_pkg::MODE_LOW:    rl_in[i] = down;
                           eisu_pkg::MODE_TOGGLE: re_in[i] = up || down;
                           eisu_pkg::MODE_FALL:   re_in[i] = down;
                           default:               re_in[i] = up;
                        endcase
                     end
                     pin_in[i] = s1_level_ff;
                  end
               end
               eisu_pkg::CMD_ENABLE: begin
                  if (en != enabled_ff[i]) begin
                     if (en) begin
                        if (mode_ff[i] == eisu_pkg::MODE_LOW) begin
                           ce_in[i] = 1'b1;
                           rl_in[i] = !old_pin;
                        end
                     end else if (mode_ff[i] == eisu_pkg::MODE_LOW) begin
                        cl_in[i] = 1'b1;
                     end else begin
                        ce_in[i] = 1'b1;
                     end
                  end
                  enabled_in[i] = en;
               end
               eisu_pkg::CMD_SENSE: begin
                  if (new_mode != mode_ff[i]) begin
                     if (enabled_ff[i]) begin
                        if (mode_ff[i] == eisu_pkg::MODE_LOW) begin
                           cl_in[i] = 1'b1;
                        end else if (new_mode == eisu_pkg::MODE_LOW) begin
                           ce_in[i] = 1'b1;
                           rl_in[i] = !old_pin;
                        end
                     end else if (new_mode == eisu_pkg::MODE_LOW) begin
                        ce_in[i] = 1'b1;
                     end
                  end
                  mode_in[i] = new_mode;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         async_ff      <= eisu_pkg::ASYNC_RESET;
         line_count_ff <= eisu_pkg::LINE_COUNT_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            eisu_pkg::CSR_ASYNC_LINES: async_ff      <= csr_chan.data;
            eisu_pkg::CSR_LINE_COUNT:  line_count_ff <= csr_chan.data[LCW-1:0];
            default: begin
            end
         endcase
      end
   end

   // line state update as a beat moves to the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         pin_ff     <= '1;
         enabled_ff <= '0;
         for (int i = 0; i < LINES; i++) begin
            mode_ff[i] <= eisu_pkg::ASYNC_RESET[i] ? eisu_pkg::MODE_FALL
                                                   : eisu_pkg::MODE_LOW;
         end
      end else if (advance) begin
         pin_ff     <= pin_in;
         enabled_ff <= enabled_in;
         for (int i = 0; i < LINES; i++) begin
            mode_ff[i] <= mode_in[i];
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff    <= req_chan.cmd;
         s1_line_ff   <= req_chan.line;
         s1_level_ff  <= req_chan.pin_level;
         s1_enable_ff <= req_chan.enable_mask;
         s1_sense_ff  <= req_chan.sense_bits;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         re_ff <= re_in;
         rl_ff <= rl_in;
         ce_ff <= ce_in;
         cl_ff <= cl_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.raise_edge  = re_ff;
   assign rsp_chan.raise_level = rl_ff;
   assign rsp_chan.clear_edge  = ce_ff;
   assign rsp_chan.clear_level = cl_ff;

endmodule
